/* design/wyhash_byte_stream_hasher_assert.svh */
// Assertion macros for the checker of the hasher.
`ifndef WYHASH_BYTE_STREAM_HASHER_ASSERT_SVH
`define WYHASH_BYTE_STREAM_HASHER_ASSERT_SVH

// Clocked assertion, switched off while reset is held.
`define WBSH_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Condition in one cycle implies an expression in the next.
`define WBSH_ASSERT_NEXT(label, cond, expr, msg) \
    `WBSH_ASSERT_CLK(label, (cond) |=> (expr), msg)

`endif

/* design/wbsh_pkg.sv */
// Package of types, commands and constants for the byte stream hasher.
`timescale 1ns / 1ps
package wbsh_pkg;

    localparam int HISTORY_BYTES_DEF = 64;
    localparam int BLOCK_BYTES       = 48;
    localparam int ROUND_BYTES       = 16;

    localparam logic [63:0] SECRET0 = 64'he0e179a6e58651db;
    localparam logic [63:0] SECRET1 = 64'h3ca9ef1e1d4dc588;
    localparam logic [63:0] SECRET2 = 64'h9fc0c1d1b5bd0cb3;
    localparam logic [63:0] SECRET3 = 64'h7e37360d82c1ff71;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT_MUL,
        ST_BLK_GA,
        ST_BLK_GB,
        ST_BLK_MUL,
        ST_WRITE,
        ST_FIN_SEL,
        ST_EMPTY_MUL,
        ST_SHORT,
        ST_LONG_GA,
        ST_LONG_GB,
        ST_RND_MUL,
        ST_F1_MUL,
        ST_F2_MUL,
        ST_OUT
    } wbsh_state_t;

    // Operand selection loaded into the multiplier at its start.
    typedef enum logic [2:0] {
        PREP_SEED,
        PREP_MAIN,
        PREP_SIDE1,
        PREP_SIDE2,
        PREP_ROUND,
        PREP_FINAL
    } wbsh_prep_t;

    // Destination of the folded product when the multiplier finishes.
    typedef enum logic [2:0] {
        WB_NONE,
        WB_LANES,
        WB_MAIN,
        WB_SIDE1,
        WB_SIDE2,
        WB_SEED,
        WB_SEED_CFG
    } wbsh_wb_t;

    typedef struct packed {
        logic       take_in;
        logic       g_start;
        logic       g_dest_b;
        logic       g_clear;
        logic [6:0] g_back;
        logic [3:0] g_len;
        logic [2:0] g_lane;
        logic       clr_ab;
        logic       m_start;
        wbsh_prep_t m_prep;
        wbsh_wb_t   m_wb;
        logic       seed_main;
        logic       seed_xor3;
        logic       write_byte;
        logic       write_blk;
        logic       out_load;
    } wbsh_cmd_t;

    typedef struct packed {
        logic       g_done;
        logic       m_done;
        logic       out_free;
        logic       cnt_zero;
        logic       pend_ge48;
        logic       len_zero;
        logic       len_le16;
        logic [4:0] len_lo;
        logic [6:0] pending;
        logic       used;
    } wbsh_status_t;

endpackage

/* design/wbsh_datapath.sv */
// Datapath of the hasher: history ring, byte gather, shared multiplier and lanes.
`timescale 1ns / 1ps
module wbsh_datapath
    import wbsh_pkg::*;
#(
    parameter int HISTORY_BYTES = HISTORY_BYTES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  wbsh_cmd_t    cmd,
    output wbsh_status_t status,
    input  logic [7:0]   in_byte,
    input  logic         cfg_wr_en,
    input  logic [63:0]  cfg_wr_data,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata
);

    localparam int AW = $clog2(HISTORY_BYTES);

    logic [7:0] ring_mem [HISTORY_BYTES];

    // Control state.
    logic [AW-1:0] wr_reg, wr_next;
    logic [63:0]   count_reg, count_next;
    logic [6:0]    pending_reg, pending_next;
    logic          used_reg, used_next;
    logic [63:0]   seed_cfg_reg, seed_cfg_next;
    logic          g_busy_reg, g_busy_next;
    logic [AW-1:0] g_addr_reg, g_addr_next;
    logic [3:0]    g_left_reg, g_left_next;
    logic          g_pend_reg, g_pend_next;
    logic [2:0]    g_pos_reg, g_pos_next;
    logic          g_dest_reg, g_dest_next;
    logic          m_busy_reg, m_busy_next;
    logic [2:0]    m_step_reg, m_step_next;
    wbsh_wb_t      m_wb_reg, m_wb_next;
    logic          out_valid_reg, out_valid_next;

    // Payload.
    logic [7:0]    byte_reg, byte_next;
    logic [7:0]    rd_data_reg;
    logic [63:0]   wa_reg, wa_next;
    logic [63:0]   wb_reg, wb_next;
    logic [63:0]   mx_reg, mx_next;
    logic [63:0]   my_reg, my_next;
    logic [63:0]   pp_reg, pp_next;
    logic [127:0]  acc_reg, acc_next;
    logic [63:0]   lane_m_reg, lane_m_next;
    logic [63:0]   lane_1_reg, lane_1_next;
    logic [63:0]   lane_2_reg, lane_2_next;
    logic [63:0]   seed_reg, seed_next;
    logic [63:0]   hash_reg, hash_next;

    logic [AW:0]   sa_sum;
    logic [AW-1:0] start_addr;
    logic [63:0]   prep_x, prep_y;
    logic [63:0]   mix_w;

    assign mix_w = acc_reg[63:0] ^ acc_reg[127:64];

    // The ring holds fewer than twice its depth past the pointer, so one subtract wraps it.
    always_comb begin
        sa_sum = {1'b0, wr_reg} + (AW+1)'(HISTORY_BYTES) - (AW+1)'(cmd.g_back);
        if (sa_sum >= (AW+1)'(HISTORY_BYTES)) begin
            start_addr = AW'(sa_sum - (AW+1)'(HISTORY_BYTES));
        end else begin
            start_addr = AW'(sa_sum);
        end
    end

    always_comb begin
        unique case (cmd.m_prep)
            PREP_SEED: begin
                prep_x = seed_cfg_reg ^ SECRET0;
                prep_y = SECRET1;
            end
            PREP_MAIN: begin
                prep_x = wa_reg ^ SECRET1;
                prep_y = wb_reg ^ lane_m_reg;
            end
            PREP_SIDE1: begin
                prep_x = wa_reg ^ SECRET2;
                prep_y = wb_reg ^ lane_1_reg;
            end
            PREP_SIDE2: begin
                prep_x = wa_reg ^ SECRET3;
                prep_y = wb_reg ^ lane_2_reg;
            end
            PREP_ROUND: begin
                prep_x = wa_reg ^ SECRET1;
                prep_y = wb_reg ^ seed_reg;
            end
            PREP_FINAL: begin
                prep_x = acc_reg[63:0] ^ SECRET0 ^ count_reg;
                prep_y = acc_reg[127:64] ^ SECRET1;
            end
            default: begin
                prep_x = '0;
                prep_y = '0;
            end
        endcase
    end

    always_comb begin
        wr_next        = wr_reg;
        count_next     = count_reg;
        pending_next   = pending_reg;
        used_next      = used_reg;
        seed_cfg_next  = seed_cfg_reg;
        g_busy_next    = g_busy_reg;
        g_addr_next    = g_addr_reg;
        g_left_next    = g_left_reg;
        g_pend_next    = g_pend_reg;
        g_pos_next     = g_pos_reg;
        g_dest_next    = g_dest_reg;
        m_busy_next    = m_busy_reg;
        m_step_next    = m_step_reg;
        m_wb_next      = m_wb_reg;
        out_valid_next = out_valid_reg;
        byte_next      = byte_reg;
        wa_next        = wa_reg;
        wb_next        = wb_reg;
        mx_next        = mx_reg;
        my_next        = my_reg;
        pp_next        = pp_reg;
        acc_next       = acc_reg;
        lane_m_next    = lane_m_reg;
        lane_1_next    = lane_1_reg;
        lane_2_next    = lane_2_reg;
        seed_next      = seed_reg;
        hash_next      = hash_reg;

        if (cmd.take_in) begin
            byte_next = in_byte;
        end
        if (cfg_wr_en) begin
            seed_cfg_next = cfg_wr_data;
        end

        // Gather: one ring read a cycle, each byte placed in the cycle after its read.
        if (cmd.g_start) begin
            g_busy_next = 1'b1;
            g_addr_next = start_addr;
            g_left_next = cmd.g_len;
            g_pend_next = 1'b0;
            g_pos_next  = cmd.g_lane;
            g_dest_next = cmd.g_dest_b;
            if (cmd.g_clear) begin
                if (cmd.g_dest_b) begin
                    wb_next = '0;
                end else begin
                    wa_next = '0;
                end
            end
        end else if (g_busy_reg) begin
            g_pend_next = (g_left_reg != 4'd0);
            if (g_left_reg != 4'd0) begin
                g_left_next = g_left_reg - 4'd1;
                if (g_addr_reg == AW'(HISTORY_BYTES - 1)) begin
                    g_addr_next = '0;
                end else begin
                    g_addr_next = g_addr_reg + AW'(1);
                end
            end
            if (g_pend_reg) begin
                if (g_dest_reg) begin
                    wb_next[8*g_pos_reg +: 8] = rd_data_reg;
                end else begin
                    wa_next[8*g_pos_reg +: 8] = rd_data_reg;
                end
                g_pos_next = g_pos_reg + 3'd1;
            end
            if (g_left_reg == 4'd0 && !g_pend_reg) begin
                g_busy_next = 1'b0;
            end
        end

        if (cmd.clr_ab) begin
            wa_next = '0;
            wb_next = '0;
        end

        // Multiplier: four 32x32 partial products summed into a 128-bit accumulator.
        if (cmd.m_start) begin
            m_busy_next = 1'b1;
            m_step_next = 3'd0;
            mx_next     = prep_x;
            my_next     = prep_y;
            m_wb_next   = cmd.m_wb;
            acc_next    = '0;
        end else if (m_busy_reg) begin
            m_step_next = m_step_reg + 3'd1;
            unique case (m_step_reg)
                3'd0: pp_next = mx_reg[31:0] * my_reg[31:0];
                3'd1: begin
                    acc_next = acc_reg + {64'd0, pp_reg};
                    pp_next  = mx_reg[31:0] * my_reg[63:32];
                end
                3'd2: begin
                    acc_next = acc_reg + {32'd0, pp_reg, 32'd0};
                    pp_next  = mx_reg[63:32] * my_reg[31:0];
                end
                3'd3: begin
                    acc_next = acc_reg + {32'd0, pp_reg, 32'd0};
                    pp_next  = mx_reg[63:32] * my_reg[63:32];
                end
                3'd4: acc_next = acc_reg + {pp_reg, 64'd0};
                3'd5: begin
                    m_busy_next = 1'b0;
                    unique case (m_wb_reg)
                        WB_NONE: ;
                        WB_LANES: begin
                            lane_m_next = seed_cfg_reg ^ mix_w;
                            lane_1_next = seed_cfg_reg ^ mix_w;
                            lane_2_next = seed_cfg_reg ^ mix_w;
                        end
                        WB_MAIN:     lane_m_next = mix_w;
                        WB_SIDE1:    lane_1_next = mix_w;
                        WB_SIDE2:    lane_2_next = mix_w;
                        WB_SEED:     seed_next   = mix_w;
                        WB_SEED_CFG: seed_next   = seed_cfg_reg ^ mix_w;
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end

        if (cmd.seed_main) begin
            seed_next = lane_m_reg;
        end
        if (cmd.seed_xor3) begin
            seed_next = lane_m_reg ^ lane_1_reg ^ lane_2_reg;
        end

        if (cmd.write_byte) begin
            if (wr_reg == AW'(HISTORY_BYTES - 1)) begin
                wr_next = '0;
            end else begin
                wr_next = wr_reg + AW'(1);
            end
            count_next   = count_reg + 64'd1;
            pending_next = cmd.write_blk ? 7'd1 : pending_reg + 7'd1;
            used_next    = used_reg | cmd.write_blk;
        end

        if (cmd.out_load) begin
            hash_next      = mix_w;
            out_valid_next = 1'b1;
            count_next     = '0;
            pending_next   = '0;
            used_next      = 1'b0;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg        <= '0;
            count_reg     <= '0;
            pending_reg   <= '0;
            used_reg      <= 1'b0;
            seed_cfg_reg  <= '0;
            g_busy_reg    <= 1'b0;
            g_addr_reg    <= '0;
            g_left_reg    <= '0;
            g_pend_reg    <= 1'b0;
            g_pos_reg     <= '0;
            g_dest_reg    <= 1'b0;
            m_busy_reg    <= 1'b0;
            m_step_reg    <= '0;
            m_wb_reg      <= WB_NONE;
            out_valid_reg <= 1'b0;
        end else begin
            wr_reg        <= wr_next;
            count_reg     <= count_next;
            pending_reg   <= pending_next;
            used_reg      <= used_next;
            seed_cfg_reg  <= seed_cfg_next;
            g_busy_reg    <= g_busy_next;
            g_addr_reg    <= g_addr_next;
            g_left_reg    <= g_left_next;
            g_pend_reg    <= g_pend_next;
            g_pos_reg     <= g_pos_next;
            g_dest_reg    <= g_dest_next;
            m_busy_reg    <= m_busy_next;
            m_step_reg    <= m_step_next;
            m_wb_reg      <= m_wb_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg   <= byte_next;
        wa_reg     <= wa_next;
        wb_reg     <= wb_next;
        mx_reg     <= mx_next;
        my_reg     <= my_next;
        pp_reg     <= pp_next;
        acc_reg    <= acc_next;
        lane_m_reg <= lane_m_next;
        lane_1_reg <= lane_1_next;
        lane_2_reg <= lane_2_next;
        seed_reg   <= seed_next;
        hash_reg   <= hash_next;
    end

    always_ff @(posedge aclk) begin
        if (cmd.write_byte) begin
            ring_mem[wr_reg] <= byte_reg;
        end
        rd_data_reg <= ring_mem[g_addr_reg];
    end

    always_comb begin
        status.g_done    = g_busy_reg && (g_left_reg == 4'd0) && !g_pend_reg;
        status.m_done    = m_busy_reg && (m_step_reg == 3'd5);
        status.out_free  = !out_valid_reg || m_tready;
        status.cnt_zero  = (count_reg == 64'd0);
        status.pend_ge48 = (pending_reg >= 7'(BLOCK_BYTES));
        status.len_zero  = (count_reg == 64'd0);
        status.len_le16  = (count_reg <= 64'(ROUND_BYTES));
        status.len_lo    = count_reg[4:0];
        status.pending   = pending_reg;
        status.used      = used_reg;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = hash_reg;

endmodule

/* design/wbsh_ctrl.sv */
// Controller state machine that sequences the hasher datapath.
`timescale 1ns / 1ps
module wbsh_ctrl
    import wbsh_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic         s_tuser,
    input  logic         s_tlast,
    input  wbsh_status_t status,
    output wbsh_cmd_t    cmd
);

    wbsh_state_t state_reg, state_next;
    logic       has_reg, has_next;
    logic       last_reg, last_next;
    logic       blk_reg, blk_next;
    logic [1:0] k_reg, k_next;
    logic [1:0] step_reg, step_next;
    logic [6:0] i_reg, i_next;
    logic       launched_reg, launched_next;

    logic [4:0] n;
    logic [6:0] s_ofs;
    logic       ge4;
    logic [6:0] long_back;

    assign n         = status.len_lo;
    assign s_ofs     = {3'd0, n[4:3], 2'b00};
    assign ge4       = (n >= 5'd4);
    assign long_back = (i_reg > 7'(ROUND_BYTES)) ? i_reg : 7'(ROUND_BYTES);

    // Next state.
    always_comb begin
        state_next    = state_reg;
        has_next      = has_reg;
        last_next     = last_reg;
        blk_next      = blk_reg;
        k_next        = k_reg;
        step_next     = step_reg;
        i_next        = i_reg;
        launched_next = launched_reg | cmd.g_start | cmd.m_start;
        if (status.g_done || status.m_done) begin
            launched_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    has_next  = s_tuser;
                    last_next = s_tlast;
                    blk_next  = status.pend_ge48;
                    k_next    = 2'd0;
                    if (s_tuser) begin
                        if (status.cnt_zero) begin
                            state_next = ST_INIT_MUL;
                        end else if (status.pend_ge48) begin
                            state_next = ST_BLK_GA;
                        end else begin
                            state_next = ST_WRITE;
                        end
                    end else if (s_tlast) begin
                        state_next = ST_FIN_SEL;
                    end
                end
            end
            ST_INIT_MUL: begin
                if (status.m_done) begin
                    state_next = blk_reg ? ST_BLK_GA : ST_WRITE;
                end
            end
            ST_BLK_GA: begin
                if (status.g_done) begin
                    state_next = ST_BLK_GB;
                end
            end
            ST_BLK_GB: begin
                if (status.g_done) begin
                    state_next = ST_BLK_MUL;
                end
            end
            ST_BLK_MUL: begin
                if (status.m_done) begin
                    if (k_reg == 2'd2) begin
                        state_next = ST_WRITE;
                    end else begin
                        k_next     = k_reg + 2'd1;
                        state_next = ST_BLK_GA;
                    end
                end
            end
            ST_WRITE: begin
                state_next = last_reg ? ST_FIN_SEL : ST_IDLE;
            end
            ST_FIN_SEL: begin
                step_next = 2'd0;
                i_next    = status.pending;
                if (status.len_zero) begin
                    state_next = ST_EMPTY_MUL;
                end else if (status.len_le16) begin
                    state_next = ST_SHORT;
                end else begin
                    state_next = ST_LONG_GA;
                end
            end
            ST_EMPTY_MUL: begin
                if (status.m_done) begin
                    state_next = ST_F1_MUL;
                end
            end
            ST_SHORT: begin
                if (status.g_done) begin
                    if (step_reg == 2'd3) begin
                        state_next = ST_F1_MUL;
                    end else begin
                        step_next = step_reg + 2'd1;
                    end
                end
            end
            ST_LONG_GA: begin
                if (status.g_done) begin
                    state_next = ST_LONG_GB;
                end
            end
            ST_LONG_GB: begin
                if (status.g_done) begin
                    state_next = (i_reg > 7'(ROUND_BYTES)) ? ST_RND_MUL : ST_F1_MUL;
                end
            end
            ST_RND_MUL: begin
                if (status.m_done) begin
                    i_next     = i_reg - 7'(ROUND_BYTES);
                    state_next = ST_LONG_GA;
                end
            end
            ST_F1_MUL: begin
                if (status.m_done) begin
                    state_next = ST_F2_MUL;
                end
            end
            ST_F2_MUL: begin
                if (status.m_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.take_in = s_tvalid;
            end
            ST_INIT_MUL: begin
                cmd.m_start = !launched_reg;
                cmd.m_prep  = PREP_SEED;
                cmd.m_wb    = WB_LANES;
            end
            ST_BLK_GA: begin
                cmd.g_start = !launched_reg;
                cmd.g_clear = 1'b1;
                cmd.g_back  = 7'(BLOCK_BYTES) - (7'(k_reg) << 4);
                cmd.g_len   = 4'd8;
            end
            ST_BLK_GB: begin
                cmd.g_start  = !launched_reg;
                cmd.g_dest_b = 1'b1;
                cmd.g_clear  = 1'b1;
                cmd.g_back   = 7'(BLOCK_BYTES - 8) - (7'(k_reg) << 4);
                cmd.g_len    = 4'd8;
            end
            ST_BLK_MUL: begin
                cmd.m_start = !launched_reg;
                unique case (k_reg)
                    2'd0: begin
                        cmd.m_prep = PREP_MAIN;
                        cmd.m_wb   = WB_MAIN;
                    end
                    2'd1: begin
                        cmd.m_prep = PREP_SIDE1;
                        cmd.m_wb   = WB_SIDE1;
                    end
                    default: begin
                        cmd.m_prep = PREP_SIDE2;
                        cmd.m_wb   = WB_SIDE2;
                    end
                endcase
            end
            ST_WRITE: begin
                cmd.write_byte = has_reg;
                cmd.write_blk  = blk_reg;
            end
            ST_FIN_SEL: begin
                cmd.clr_ab    = status.len_zero;
                cmd.seed_main = !status.len_zero && (status.len_le16 || !status.used);
                cmd.seed_xor3 = !status.len_zero && !status.len_le16 && status.used;
            end
            ST_EMPTY_MUL: begin
                cmd.m_start = !launched_reg;
                cmd.m_prep  = PREP_SEED;
                cmd.m_wb    = WB_SEED_CFG;
            end
            ST_SHORT: begin
                cmd.g_start = !launched_reg;
                // Messages of four bytes or more read two overlapping words from each end;
                // shorter ones take the first, middle and last byte.
                unique case (step_reg)
                    2'd0: begin
                        cmd.g_clear = 1'b1;
                        cmd.g_back  = 7'(n);
                        cmd.g_len   = ge4 ? 4'd4 : 4'd1;
                        cmd.g_lane  = ge4 ? 3'd4 : 3'd2;
                    end
                    2'd1: begin
                        cmd.g_back = ge4 ? 7'(n) - s_ofs : 7'(n) - 7'(n >> 1);
                        cmd.g_len  = ge4 ? 4'd4 : 4'd1;
                        cmd.g_lane = ge4 ? 3'd0 : 3'd1;
                    end
                    2'd2: begin
                        cmd.g_dest_b = ge4;
                        cmd.g_clear  = ge4;
                        cmd.g_back   = ge4 ? 7'd4 : 7'd1;
                        cmd.g_len    = ge4 ? 4'd4 : 4'd1;
                        cmd.g_lane   = ge4 ? 3'd4 : 3'd0;
                    end
                    default: begin
                        cmd.g_dest_b = 1'b1;
                        cmd.g_clear  = !ge4;
                        cmd.g_back   = 7'd4 + s_ofs;
                        cmd.g_len    = ge4 ? 4'd4 : 4'd0;
                        cmd.g_lane   = 3'd0;
                    end
                endcase
            end
            ST_LONG_GA: begin
                cmd.g_start = !launched_reg;
                cmd.g_clear = 1'b1;
                cmd.g_back  = long_back;
                cmd.g_len   = 4'd8;
            end
            ST_LONG_GB: begin
                cmd.g_start  = !launched_reg;
                cmd.g_dest_b = 1'b1;
                cmd.g_clear  = 1'b1;
                cmd.g_back   = long_back - 7'd8;
                cmd.g_len    = 4'd8;
            end
            ST_RND_MUL: begin
                cmd.m_start = !launched_reg;
                cmd.m_prep  = PREP_ROUND;
                cmd.m_wb    = WB_SEED;
            end
            ST_F1_MUL: begin
                cmd.m_start = !launched_reg;
                cmd.m_prep  = PREP_ROUND;
                cmd.m_wb    = WB_NONE;
            end
            ST_F2_MUL: begin
                cmd.m_start = !launched_reg;
                cmd.m_prep  = PREP_FINAL;
                cmd.m_wb    = WB_NONE;
            end
            ST_OUT: begin
                cmd.out_load = status.out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            has_reg      <= 1'b0;
            last_reg     <= 1'b0;
            blk_reg      <= 1'b0;
            k_reg        <= '0;
            step_reg     <= '0;
            i_reg        <= '0;
            launched_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            has_reg      <= has_next;
            last_reg     <= last_next;
            blk_reg      <= blk_next;
            k_reg        <= k_next;
            step_reg     <= step_next;
            i_reg        <= i_next;
            launched_reg <= launched_next;
        end
    end

endmodule

/* design/wyhash_byte_stream_hasher.sv */
// Top level of the streaming 64-bit wyhash byte hasher.
//
// Bytes of a message arrive one per input beat and the hash leaves as one output beat after
// the beat marked last; an empty message is a last beat with tuser low. The block works on one
// beat at a time: an ordinary byte is accepted and then written to the ring. The byte that
// follows each full 48-byte block first folds that block into three lanes, bound by the single
// read port of the history ring and the shared 32x32 multiplier; the first byte of a message
// adds one product for the seed. Once the end of a message is worked off, the next message may
// start while the hash still waits in the output register.
`timescale 1ns / 1ps
module wyhash_byte_stream_hasher
    import wbsh_pkg::*;
#(
    parameter int HISTORY_BYTES = HISTORY_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [63:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] has_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // [63:0] hash_value
);

    wbsh_cmd_t    cmd;
    wbsh_status_t status;

    wbsh_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .status   (status),
        .cmd      (cmd)
    );

    wbsh_datapath #(
        .HISTORY_BYTES (HISTORY_BYTES)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .in_byte     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

/* design/wbsh_checker.sv */
// Port-level checker for the byte stream hasher, bound to the top level.
`timescale 1ns / 1ps
`include "wyhash_byte_stream_hasher_assert.svh"
module wbsh_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    // A beat that carries a byte or ends a message always keeps the block busy afterwards.
    `WBSH_ASSERT_NEXT(a_busy_after_work, s_tvalid && s_tready && (s_tuser || s_tlast), !s_tready, "input ready right after a working beat")

    // A beat with neither a byte nor the end mark is dropped and the block stays ready.
    `WBSH_ASSERT_NEXT(a_ready_after_idle_beat, s_tvalid && s_tready && !s_tuser && !s_tlast, s_tready, "input not ready after an empty beat")

    `WBSH_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled hash beat changed")

endmodule

bind wyhash_byte_stream_hasher wbsh_checker u_wbsh_checker (.*);

/* sim/tb_top.sv */
// Self-checking testbench for the streaming wyhash byte hasher.
`timescale 1ns / 1ps
module tb_top;
    import wbsh_pkg::*;

    class wyhash_scoreboard;
        logic [7:0]  ring [64];
        int          wr_ptr;
        logic [63:0] msg_len;
        logic [63:0] lane_main, lane_one, lane_two;
        bit          blocks_seen;
        int          pending;
        logic [63:0] seed_reg;
        logic [63:0] hash_queue [$];

        function new();
            foreach (ring[i]) ring[i] = 8'h00;
            wr_ptr = 0;
            msg_len = 0;
            lane_main = 0;
            lane_one = 0;
            lane_two = 0;
            blocks_seen = 0;
            pending = 0;
            seed_reg = 0;
        endfunction

        function logic [127:0] mul_wide(logic [63:0] x, logic [63:0] y);
            return {64'd0, x} * {64'd0, y};
        endfunction

        function logic [63:0] fold_mix(logic [63:0] x, logic [63:0] y);
            logic [127:0] p;
            p = mul_wide(x, y);
            return p[127:64] ^ p[63:0];
        endfunction

        function logic [63:0] byte_back(int back);
            return {56'd0, ring[(wr_ptr + 64 - (back % 64)) % 64]};
        endfunction

        // Little-endian word whose first byte lies 'back' bytes in the past.
        function logic [63:0] word_back(int back, int n);
            logic [63:0] v;
            v = 0;
            for (int k = 0; k < n; k++) v |= byte_back(back - k) << (8 * k);
            return v;
        endfunction

        function logic [63:0] seed_mixed(logic [63:0] s);
            return s ^ fold_mix(s ^ SECRET0, SECRET1);
        endfunction

        function logic [63:0] final_hash();
            logic [63:0] sd, a, b;
            logic [127:0] p;
            int i, n, s;
            if (msg_len == 0) begin
                sd = seed_mixed(seed_reg);
                a = 0;
                b = 0;
            end else if (msg_len <= ROUND_BYTES) begin
                n = int'(msg_len);
                sd = lane_main;
                if (n >= 4) begin
                    s = (n >> 3) << 2;
                    a = (word_back(n, 4) << 32) | word_back(n - s, 4);
                    b = (word_back(4, 4) << 32) | word_back(4 + s, 4);
                end else begin
                    a = (byte_back(n) << 16) | (byte_back(n - (n >> 1)) << 8) | byte_back(1);
                    b = 0;
                end
            end else begin
                i = pending;
                sd = lane_main;
                if (blocks_seen) sd ^= lane_one ^ lane_two;
                while (i > ROUND_BYTES) begin
                    sd = fold_mix(word_back(i, 8) ^ SECRET1, word_back(i - 8, 8) ^ sd);
                    i -= ROUND_BYTES;
                end
                a = word_back(16, 8);
                b = word_back(8, 8);
            end
            p = mul_wide(a ^ SECRET1, b ^ sd);
            return fold_mix(p[63:0] ^ SECRET0 ^ msg_len, p[127:64] ^ SECRET1);
        endfunction

        function void note_beat(logic [7:0] data, bit has, bit last);
            logic [63:0] s;
            if (has) begin
                if (msg_len == 0) begin
                    s = seed_mixed(seed_reg);
                    lane_main = s;
                    lane_one = s;
                    lane_two = s;
                end
                if (pending >= BLOCK_BYTES) begin
                    lane_main = fold_mix(word_back(48, 8) ^ SECRET1, word_back(40, 8) ^ lane_main);
                    lane_one = fold_mix(word_back(32, 8) ^ SECRET2, word_back(24, 8) ^ lane_one);
                    lane_two = fold_mix(word_back(16, 8) ^ SECRET3, word_back(8, 8) ^ lane_two);
                    blocks_seen = 1;
                    pending = 0;
                end
                ring[wr_ptr] = data;
                wr_ptr = (wr_ptr + 1) % 64;
                pending++;
                msg_len++;
            end
            if (last) begin
                hash_queue.push_back(final_hash());
                msg_len = 0;
                pending = 0;
                blocks_seen = 0;
            end
        endfunction

        // Returns 0 on a mismatch or when no hash is waiting.
        function bit check_hash(logic [63:0] got, output logic [63:0] want, output bit none);
            none = (hash_queue.size() == 0);
            want = 0;
            if (none) return 0;
            want = hash_queue.pop_front();
            return got === want;
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_wr_en = 0;
    logic [63:0] cfg_wr_data = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [7:0]  s_tdata = 0;   // [7:0] data_byte
    logic        s_tuser = 0;   // [0] has_byte
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [63:0] m_tdata;       // [63:0] hash_value

    wyhash_byte_stream_hasher DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    wyhash_scoreboard sb = new();
    int  error_count = 0;
    int  bytes_sent = 0;
    bit  idle_off = 0;
    bit  hold_request = 0;

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("ERROR %s: got %016h expected %016h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Result side: random stall bursts, plus one long hold-off on request.
    initial begin
        int burst;
        burst = 0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_tready <= 0;
                for (int c = 0; c < 3000; c++) @(negedge aclk);
                hold_request = 0;
                m_tready <= 1;
            end else if (burst > 0) begin
                burst--;
            end else if (!idle_off && $urandom_range(0, 9) == 0) begin
                burst = $urandom_range(0, 6);
                m_tready <= 0;
            end else begin
                m_tready <= 1;
            end
        end
    end

    always @(posedge aclk) begin
        logic [63:0] want;
        bit none;
        if (aresetn && m_tvalid && m_tready) begin
            if (!sb.check_hash(m_tdata, want, none))
                report(none ? "unexpected hash beat" : "hash_value", m_tdata, want);
        end
    end

    // The beat stays offered after its acceptance until the next one or an explicit drop.
    task automatic send_beat(logic [7:0] data, bit has, bit last);
        if (!idle_off && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= data;
        s_tuser <= has;
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        sb.note_beat(data, has, last);
        if (has) bytes_sent++;
        @(negedge aclk);
    endtask

    // A message of len bytes; sep_end closes it with a byte-less last beat.
    task automatic send_message(int len, bit sep_end, int fill);
        logic [7:0] d;
        if (len == 0) begin
            send_beat(8'($urandom), 0, 1);
        end else begin
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 30) == 0) send_beat(8'($urandom), 0, 0);
                d = (fill >= 0) ? fill[7:0] : 8'($urandom);
                send_beat(d, 1, (k == len - 1) && !sep_end);
            end
            if (sep_end) send_beat(8'($urandom), 0, 1);
        end
    endtask

    task automatic random_message();
        int r, len;
        r = $urandom_range(0, 99);
        if (r < 70) len = $urandom_range(0, 20);
        else if (r < 95) len = $urandom_range(21, 110);
        else len = $urandom_range(111, 200);
        send_message(len, $urandom_range(0, 4) == 0, -1);
    endtask

    // Waits for every hash, then for the longest possible end-of-message work.
    task automatic drain_and_set_seed(logic [63:0] seed);
        s_tvalid <= 0;
        while (sb.hash_queue.size() != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
        cfg_wr_en <= 1;
        cfg_wr_data <= seed;
        sb.seed_reg = seed;
        @(negedge aclk);
        cfg_wr_en <= 0;
    endtask

    initial begin
        logic [63:0] seeds [4];
        seeds[0] = '1;
        seeds[1] = {$urandom, $urandom};
        seeds[2] = 64'h8000_0000_0000_0000;
        seeds[3] = {$urandom, $urandom};
        repeat (6) @(negedge aclk);
        aresetn <= 1;
        drain_and_set_seed(64'd0);

        // Directed: empty message, three-byte path, short paths, one and two rounds, one block fold.
        send_message(0, 0, -1);
        send_beat(8'h11, 0, 0);
        send_message(1, 0, 8'hff);
        send_message(3, 0, 8'h00);
        send_message(4, 1, 8'hff);
        send_message(16, 0, -1);
        send_message(17, 0, 8'hff);
        send_message(48, 0, -1);
        send_message(49, 1, -1);

        for (int ph = 0; ph < 4; ph++) begin
            drain_and_set_seed(seeds[ph]);
            if (ph == 3) idle_off = 1;
            if (ph == 1) begin
                hold_request = 1;
                repeat (6) random_message();
            end
            while (bytes_sent < 250 * (ph + 1)) random_message();
        end

        s_tvalid <= 0;
        while (sb.hash_queue.size() != 0) @(negedge aclk);
        repeat (200) @(posedge aclk);
        if (error_count == 0) $display("wyhash_byte_stream_hasher: match");
        else $display("wyhash_byte_stream_hasher: mismatch");
        $finish;
    end

    initial begin
        #40ms;
        $display("wyhash_byte_stream_hasher: mismatch");
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/wbsh_pkg.sv
design/wbsh_datapath.sv
design/wbsh_ctrl.sv
design/wyhash_byte_stream_hasher.sv
design/wbsh_checker.sv
sim/tb_top.sv
